// File: sv/tprf_pkg.sv
// Shared constants, register indexes and control structs of the tachometer filter.
package tprf_pkg;

  localparam int unsigned TICK_RATE_HZ = 1000000;

  localparam int unsigned SCALE_W  = 16;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned THR_W    = 16;
  localparam int unsigned FILT_W   = 24;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 2;

  // numerator of the rate division: tick rate times Q8.8 scale
  localparam int unsigned TICK_W  = $clog2(TICK_RATE_HZ + 1);
  localparam int unsigned NUM_W   = TICK_W + SCALE_W;
  localparam int unsigned CNT_W   = $clog2(NUM_W);

  // 5*filt + raw stays below 6*2^24
  localparam int unsigned ACC_W   = 27;
  // divide by six: multiply by floor(2^30/6), then one correction step
  localparam int unsigned RECIP_SH = 30;
  localparam int unsigned RECIP_W  = 28;
  localparam logic [RECIP_W-1:0] RECIP_SIX = RECIP_W'((64'd1 << RECIP_SH) / 64'd6);
  localparam int unsigned PROD_W  = ACC_W + RECIP_W;

  localparam logic [CFG_IDX_W-1:0] CFG_RATE_SCALE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_THRESH   = 2'd2;

  localparam logic [SCALE_W-1:0] RATE_SCALE_RST = 16'd256;
  localparam logic [TIME_W-1:0]  TIMEOUT_RST    = 32'd200000;
  localparam logic [THR_W-1:0]   RUN_THRESH_RST = 16'd100;

  typedef struct packed {
    logic edge_load;
    logic smp_start;
    logic div_step;
    logic acc_load;
    logic mul_load;
    logic done_load;
  } tprf_cmd_t;

  typedef struct packed {
    logic zero_raw;
    logic div_last;
  } tprf_sts_t;

endpackage

// File: sv/tprf_ctrl.sv
// Sequencer of the tachometer filter: handshakes and step commands for the datapath.
module tprf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  tprf_pkg::tprf_sts_t  sts,
  output tprf_pkg::tprf_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (!in_mode) begin
            cmd.edge_load = 1'b1;
          end else begin
            cmd.smp_start = 1'b1;
            state_nxt = sts.zero_raw ? S_ACC : S_DIV;
          end
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_load = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.done_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.done_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done_load |-> (!out_valid_r || out_ready))
    else $error("result beat overwritten before it was taken");

  a_rise_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_DONE))
    else $error("result beat raised outside the done step");

  a_sample_divides: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && in_valid && in_mode && !sts.zero_raw) |=> (state_r == S_DIV))
    else $error("live sample did not start the divider");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && sts.div_last) |=> (state_r == S_ACC))
    else $error("divider did not hand over after its last step");

endmodule

// File: sv/tprf_dp.sv
// Datapath of the tachometer filter: config, edge state, serial divider and 5/6 filter.
module tprf_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tprf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tprf_pkg::CFG_W-1:0]        cfg_data,
  input  logic [tprf_pkg::TIME_W-1:0]       in_timestamp,
  input  tprf_pkg::tprf_cmd_t               cmd,
  output tprf_pkg::tprf_sts_t               sts,
  output logic [tprf_pkg::RATE_W-1:0]       out_rate,
  output logic                              out_running
);

  logic [tprf_pkg::SCALE_W-1:0] rate_scale_r;
  logic [tprf_pkg::TIME_W-1:0]  timeout_r;
  logic [tprf_pkg::THR_W-1:0]   run_thresh_r;

  logic [tprf_pkg::TIME_W-1:0]  last_edge_r;
  logic [tprf_pkg::TIME_W-1:0]  period_r;
  logic [tprf_pkg::FILT_W-1:0]  filt_r;

  logic [tprf_pkg::NUM_W-1:0]   q_r;
  logic [tprf_pkg::TIME_W-1:0]  rem_r;
  logic [tprf_pkg::CNT_W-1:0]   cnt_r;
  logic                         zero_r;
  logic [tprf_pkg::ACC_W-1:0]   acc_r;
  logic [tprf_pkg::PROD_W-1:0]  prod_r;
  logic [tprf_pkg::RATE_W-1:0]  rate_r;
  logic                         running_r;

  logic [tprf_pkg::TIME_W-1:0]  elapsed;
  logic [tprf_pkg::NUM_W-1:0]   num;
  logic [tprf_pkg::TIME_W:0]    trial;
  logic [tprf_pkg::TIME_W:0]    trial_diff;
  logic                         ge;
  logic [tprf_pkg::FILT_W-1:0]  raw;
  logic [tprf_pkg::FILT_W-1:0]  q_est;
  logic [tprf_pkg::ACC_W-1:0]   rem6;
  logic [tprf_pkg::FILT_W-1:0]  filt_new;
  logic [tprf_pkg::RATE_W-1:0]  whole_new;

  assign elapsed = in_timestamp - last_edge_r;
  assign sts.zero_raw = (period_r == '0) || (elapsed > timeout_r);
  assign sts.div_last = (cnt_r == tprf_pkg::CNT_W'(tprf_pkg::NUM_W - 1));

  assign num = {{tprf_pkg::TICK_W{1'b0}}, rate_scale_r}
             * tprf_pkg::NUM_W'(tprf_pkg::TICK_RATE_HZ);

  // restoring division, one quotient bit a step
  assign trial      = {rem_r, q_r[tprf_pkg::NUM_W-1]};
  assign trial_diff = trial - {1'b0, period_r};
  assign ge         = (trial >= {1'b0, period_r});

  // saturate the quotient to 24 bits, or force zero when the rate reads zero
  always_comb begin
    if (zero_r) raw = '0;
    else if (q_r[tprf_pkg::NUM_W-1:tprf_pkg::FILT_W] != '0) raw = '1;
    else raw = q_r[tprf_pkg::FILT_W-1:0];
  end

  // estimate is floor(acc/6) or one below it
  assign q_est = prod_r[tprf_pkg::RECIP_SH +: tprf_pkg::FILT_W];
  assign rem6  = acc_r - ({1'b0, q_est, 2'b00} + {2'b00, q_est, 1'b0});
  assign filt_new  = q_est + tprf_pkg::FILT_W'(rem6 >= tprf_pkg::ACC_W'(6));
  assign whole_new = filt_new[tprf_pkg::FILT_W-1 -: tprf_pkg::RATE_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_scale_r <= tprf_pkg::RATE_SCALE_RST;
      timeout_r    <= tprf_pkg::TIMEOUT_RST;
      run_thresh_r <= tprf_pkg::RUN_THRESH_RST;
      last_edge_r  <= '0;
      period_r     <= '0;
      filt_r       <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          tprf_pkg::CFG_RATE_SCALE: rate_scale_r <= cfg_data[tprf_pkg::SCALE_W-1:0];
          tprf_pkg::CFG_TIMEOUT:    timeout_r    <= cfg_data[tprf_pkg::TIME_W-1:0];
          tprf_pkg::CFG_RUN_THRESH: run_thresh_r <= cfg_data[tprf_pkg::THR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.edge_load) begin
        period_r    <= elapsed;
        last_edge_r <= in_timestamp;
      end
      if (cmd.done_load) filt_r <= filt_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.smp_start) begin
      q_r    <= num;
      rem_r  <= '0;
      cnt_r  <= '0;
      zero_r <= sts.zero_raw;
    end else if (cmd.div_step) begin
      rem_r <= ge ? trial_diff[tprf_pkg::TIME_W-1:0] : trial[tprf_pkg::TIME_W-1:0];
      q_r   <= {q_r[tprf_pkg::NUM_W-2:0], ge};
      cnt_r <= cnt_r + tprf_pkg::CNT_W'(1);
    end
    if (cmd.acc_load) begin
      acc_r <= {1'b0, filt_r, 2'b00} + {3'b000, filt_r} + {3'b000, raw};
    end
    if (cmd.mul_load) begin
      prod_r <= {{tprf_pkg::RECIP_W{1'b0}}, acc_r}
              * {{tprf_pkg::ACC_W{1'b0}}, tprf_pkg::RECIP_SIX};
    end
    if (cmd.done_load) begin
      rate_r    <= whole_new;
      running_r <= (whole_new >= run_thresh_r);
    end
  end

  assign out_rate    = rate_r;
  assign out_running = running_r;

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.div_step) |-> (rem_r < period_r))
    else $error("divider remainder not below divisor");

  a_fix_small: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.done_load |-> (rem6 < tprf_pkg::ACC_W'(12)))
    else $error("divide-by-six estimate off by more than one");

  a_filt_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!$past(cmd.done_load) && $past(rst_n)) |-> $stable(filt_r))
    else $error("filter state changed outside a result step");

endmodule

// File: sv/tach_period_rate_filter_unit.sv
// Top level of the period-capture tachometer with 5/6 rate filter.
// Edge beat: taken with no result; the block stays ready for the next beat.
// Sample beat: the one-bit-a-step rate divider runs over NUM_W steps (skipped when the rate
// reads zero), then accumulate, multiply and done give the result; no new sample until idle.
// Synchronous active-low reset: config to defaults, edge time, period and filter to zero.
module tach_period_rate_filter_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_mode,
  input  logic [tprf_pkg::TIME_W-1:0]     in_timestamp,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [tprf_pkg::RATE_W-1:0]     out_rate,
  output logic                            out_running,
  input  logic                            cfg_we,
  input  logic [tprf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tprf_pkg::CFG_W-1:0]      cfg_data
);

  tprf_pkg::tprf_cmd_t cmd;
  tprf_pkg::tprf_sts_t sts;

  tprf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tprf_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_timestamp (in_timestamp),
    .cmd          (cmd),
    .sts          (sts),
    .out_rate     (out_rate),
    .out_running  (out_running)
  );

endmodule
